FILE: sv/length_prefixed_frame_deframer_defines.svh
// Assertion macros for the length-prefixed frame deframer.
// Depends on nothing; the including module provides aclk and aresetn.
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define LPFD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Next-cycle implication, checked outside reset
`define LPFD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

FILE: sv/lpfd_pkg.sv
// Shared types and constants for the length-prefixed frame deframer.
// No dependencies.
package lpfd_pkg;

    localparam int HDR_STORE_DEPTH = 23;
    localparam int HCOUNT_W        = 5;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 32;
    localparam int QDEPTH          = 4;
    localparam int QPTR_W          = 2;
    localparam int QCNT_W          = 3;
    localparam int TDATA_W         = 200;
    localparam int TDATA_USED      = 193;

    localparam logic [7:0]  VERSION_RST     = 8'd1;
    localparam logic [31:0] MAX_PAYLOAD_RST = 32'd1048576;

    localparam logic [CFG_IDX_W-1:0] CFG_VERSION     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 1'd1;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_REJECT  = 2'd2;

    localparam logic ERR_VERSION  = 1'b0;
    localparam logic ERR_TOO_LONG = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  frame_type;
        logic [15:0] flags;
        logic [63:0] rid_high;
        logic [63:0] rid_low;
        logic [31:0] length;
        logic [7:0]  data;
        logic        err;
        logic        last;
    } entry_t;

    typedef struct packed {
        logic                in_payload;
        logic [HCOUNT_W-1:0] hcount;
    } front_status_t;

endpackage

FILE: sv/lpfd_front.sv
// Front end: accepts bytes, assembles and checks headers, tracks payload.
// Depends on lpfd_pkg.
module lpfd_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [lpfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lpfd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       in_byte,
    input  logic                             q_full,
    output logic                             push,
    output lpfd_pkg::entry_t                 push_entry,
    output lpfd_pkg::front_status_t          status
);

    logic [7:0]                    version_reg;
    logic [31:0]                   max_reg;
    logic                          in_payload_reg, in_payload_next;
    logic [lpfd_pkg::HCOUNT_W-1:0] hcount_reg, hcount_next;
    logic [31:0]                   left_reg, left_next;
    logic [7:0]                    hstore_reg [lpfd_pkg::HDR_STORE_DEPTH];
    logic                          accept;
    logic                          shift_en;
    logic [31:0]                   hdr_len;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    // hstore_reg[0] holds the newest byte, so header byte i sits at index 22-i
    assign hdr_len  = {hstore_reg[2], hstore_reg[1], hstore_reg[0], in_byte};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            version_reg <= lpfd_pkg::VERSION_RST;
            max_reg     <= lpfd_pkg::MAX_PAYLOAD_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                lpfd_pkg::CFG_VERSION:     version_reg <= cfg_data[7:0];
                lpfd_pkg::CFG_MAX_PAYLOAD: max_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        in_payload_next       = in_payload_reg;
        hcount_next           = hcount_reg;
        left_next             = left_reg;
        shift_en              = 1'b0;
        push                  = 1'b0;
        push_entry.kind       = lpfd_pkg::KIND_PAYLOAD;
        push_entry.frame_type = hstore_reg[21];
        push_entry.flags      = {hstore_reg[20], hstore_reg[19]};
        push_entry.rid_high   = {hstore_reg[18], hstore_reg[17], hstore_reg[16], hstore_reg[15],
                                 hstore_reg[14], hstore_reg[13], hstore_reg[12], hstore_reg[11]};
        push_entry.rid_low    = {hstore_reg[10], hstore_reg[9], hstore_reg[8], hstore_reg[7],
                                 hstore_reg[6], hstore_reg[5], hstore_reg[4], hstore_reg[3]};
        push_entry.length     = hdr_len;
        push_entry.data       = in_byte;
        push_entry.err        = lpfd_pkg::ERR_VERSION;
        push_entry.last       = 1'b0;
        if (accept) begin
            if (in_payload_reg) begin
                push            = 1'b1;
                push_entry.last = (left_reg == 32'd1);
                left_next       = left_reg - 32'd1;
                if (left_reg == 32'd1) begin
                    in_payload_next = 1'b0;
                end
            end else if (hcount_reg < lpfd_pkg::HCOUNT_W'(lpfd_pkg::HDR_STORE_DEPTH)) begin
                shift_en    = 1'b1;
                hcount_next = hcount_reg + 1'b1;
            end else begin
                push        = 1'b1;
                hcount_next = '0;
                if (hstore_reg[22] != version_reg) begin
                    push_entry.kind = lpfd_pkg::KIND_REJECT;
                    push_entry.err  = lpfd_pkg::ERR_VERSION;
                end else if (hdr_len > max_reg) begin
                    push_entry.kind = lpfd_pkg::KIND_REJECT;
                    push_entry.err  = lpfd_pkg::ERR_TOO_LONG;
                end else begin
                    push_entry.kind = lpfd_pkg::KIND_HEADER;
                    push_entry.last = (hdr_len == 32'd0);
                    if (hdr_len != 32'd0) begin
                        in_payload_next = 1'b1;
                        left_next       = hdr_len;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_payload_reg <= 1'b0;
            hcount_reg     <= '0;
            left_reg       <= '0;
        end else begin
            in_payload_reg <= in_payload_next;
            hcount_reg     <= hcount_next;
            left_reg       <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            hstore_reg[0] <= in_byte;
            for (int i = 1; i < lpfd_pkg::HDR_STORE_DEPTH; i++) begin
                hstore_reg[i] <= hstore_reg[i-1];
            end
        end
    end

    assign status.in_payload = in_payload_reg;
    assign status.hcount     = hcount_reg;

endmodule

FILE: sv/lpfd_queue.sv
// Short queue of classified transactions between front and back.
// Depends on lpfd_pkg.
module lpfd_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  lpfd_pkg::entry_t  push_entry,
    input  logic              pop,
    output logic              q_valid,
    output logic              q_full,
    output lpfd_pkg::entry_t  q_entry
);

    lpfd_pkg::entry_t              mem_reg [lpfd_pkg::QDEPTH];
    logic [lpfd_pkg::QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [lpfd_pkg::QCNT_W-1:0]   count_reg, count_next;

    assign q_valid = (count_reg != '0);
    assign q_full  = (count_reg == lpfd_pkg::QCNT_W'(lpfd_pkg::QDEPTH));
    assign q_entry = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: sv/lpfd_back.sv
// Back end: formats queued transactions into results and holds the output register.
// Depends on lpfd_pkg.
module lpfd_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_valid,
    input  lpfd_pkg::entry_t                q_entry,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lpfd_pkg::TDATA_W-1:0]    m_tdata,
    output logic [1:0]                      m_tuser,
    output logic                            m_tlast
);

    logic                          valid_reg;
    logic [lpfd_pkg::TDATA_W-1:0]  data_reg, data_next;
    logic [1:0]                    kind_reg;
    logic                          last_reg;

    assign pop = q_valid && (!valid_reg || m_tready);

    // Zero every field that does not belong to the transaction's kind
    always_comb begin
        data_next = '0;
        case (q_entry.kind)
            lpfd_pkg::KIND_HEADER: begin
                data_next[183:0] = {q_entry.length, q_entry.rid_low, q_entry.rid_high,
                                    q_entry.flags, q_entry.frame_type};
            end
            lpfd_pkg::KIND_PAYLOAD: begin
                data_next[191:184] = q_entry.data;
            end
            lpfd_pkg::KIND_REJECT: begin
                data_next[192] = q_entry.err;
            end
            default: data_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            data_reg <= data_next;
            kind_reg <= q_entry.kind;
            last_reg <= q_entry.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

FILE: sv/length_prefixed_frame_deframer.sv
// Length-prefixed frame deframer: one byte accepted per cycle, sustained while m_tready is high.
// A result is written to the 4-entry transaction queue when its byte is accepted and is
// then loaded into the output register, which drives m_tvalid, once that register is free;
// s_tready drops only when the queue fills under output back-pressure.
// Reset (synchronous, aresetn low): hunting for a header, queue and output empty,
// version register back to 1 and length limit back to 1048576.
`include "length_prefixed_frame_deframer_defines.svh"

module length_prefixed_frame_deframer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [lpfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lpfd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // data_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // frame type, flags, request id high, request id low, length, payload byte,
    // error code, zero padding
    output logic [lpfd_pkg::TDATA_W-1:0]    m_tdata,
    output logic [1:0]                      m_tuser,  // kind
    output logic                            m_tlast
);

    logic                    push, pop, q_valid, q_full;
    lpfd_pkg::entry_t        push_entry, q_entry;
    lpfd_pkg::front_status_t front_status;

    lpfd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry),
        .status     (front_status)
    );

    lpfd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_full     (q_full),
        .q_entry    (q_entry)
    );

    lpfd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Header collection restarts from zero whenever a payload is in flight
    `LPFD_ASSERT_IMP(a_payload_no_hdr, front_status.in_payload, front_status.hcount == '0)
    // A rejection never closes a frame
    `LPFD_ASSERT_IMP(a_reject_not_last, m_tvalid && m_tlast, m_tuser != lpfd_pkg::KIND_REJECT)
    // A rejection carries only its error code
    `LPFD_ASSERT_IMP(a_reject_clean, m_tvalid && m_tuser == lpfd_pkg::KIND_REJECT, m_tdata[191:0] == '0)

endmodule
